// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("item checker: same-cycle rule broken");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("item checker: next-cycle rule broken");

// Plain condition at every edge, reset included.
`define CHK_ALWAYS(label, clk, cond) \
   label: assert property (@(posedge clk) (cond)) \
      else $error("item checker: invariant broken");

`endif

// File: rtl/bt_pkg.sv
// ----------------------------------------------------------------------------
// bt_pkg
// Types shared by the binomial transform stream block.
// ----------------------------------------------------------------------------
package bt_pkg;

   localparam int VALUE_W  = 32;
   localparam int RESULT_W = 64;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } bt_req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] result;
      logic                       last_out;
      logic                       overflow;
   } bt_rsp_type;

   // wavefront token travelling down the cell row
   typedef struct packed {
      logic                act;
      logic [RESULT_W-1:0] value;
   } bt_token_type;

   // final difference reported by the cell that ends the wavefront
   typedef struct packed {
      logic                hit;
      logic [RESULT_W-1:0] value;
   } bt_hit_type;

endpackage

// File: rtl/bt_stream_if.sv
// ----------------------------------------------------------------------------
// bt_req_if / bt_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface bt_req_if;
   logic               valid;
   logic               ready;
   bt_pkg::bt_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bt_rsp_if;
   logic               valid;
   logic               ready;
   bt_pkg::bt_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bt_cell.sv
// ----------------------------------------------------------------------------
// bt_cell
// One difference cell: holds one diagonal entry and forwards the wavefront.
// ----------------------------------------------------------------------------
module bt_cell #(
   parameter int CNT_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bt_pkg::bt_token_type tok_i,
   input  logic [CNT_W-1:0]     cnt_i,
   output bt_pkg::bt_token_type tok_o,
   output logic [CNT_W-1:0]     cnt_o,
   output bt_pkg::bt_hit_type   hit_o
);

   logic [bt_pkg::RESULT_W-1:0] diag_ff;
   logic                        act_ff;
   logic                        act_in;
   logic [bt_pkg::RESULT_W-1:0] val_ff;
   logic [bt_pkg::RESULT_W-1:0] val_in;
   logic [CNT_W-1:0]            cnt_ff;
   logic [CNT_W-1:0]            cnt_in;
   logic                        tail;

   always_comb begin
      tail   = (cnt_i == '0);
      val_in = tok_i.value - diag_ff;
      act_in = tok_i.act && !tail;
      cnt_in = cnt_i - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   // payload: replace the diagonal entry with the incoming token value
   always_ff @(posedge clock) begin
      val_ff <= val_in;
      cnt_ff <= cnt_in;
      if (tok_i.act) begin
         diag_ff <= tok_i.value;
      end
   end

   assign tok_o.act   = act_ff;
   assign tok_o.value = val_ff;
   assign cnt_o       = cnt_ff;
   assign hit_o.hit   = tok_i.act && tail;
   assign hit_o.value = tok_i.value;

endmodule

// File: rtl/binomial_transform_stream_top.sv
// ----------------------------------------------------------------------------
// binomial_transform_stream_top
// Streaming binomial transform over a row of forward-difference cells.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                               handshake
//   --------  ----  ------------------------------------  -----------------
//   req_chan  in    value[31:0] signed, last              valid/ready
//   rsp_chan  out   result[63:0] signed, last_out,        valid/ready
//                   overflow
//
// An element with index n inside the sequence walks n+1 cells of the row,
// one cell a cycle; its result goes from the ending cell into the pending
// register, then into the output register. One item is in the row at a
// time, and the next item is taken the cycle after the result moves into
// the output register. An overflowing element skips the row into pending.
// Reset is synchronous and clears the sequence position and all valids.
// A stalled rsp_chan holds the output register; one more result parks in
// a pending register, and req_chan stays not ready until it moves on.
// ----------------------------------------------------------------------------
module binomial_transform_stream_top #(
   parameter int MAX_LEN = 64
) (
   input  logic           clock,
   input  logic           reset,
   bt_req_if.sink         req_chan,
   bt_rsp_if.source       rsp_chan
);

   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam int CNT_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int RW    = bt_pkg::RESULT_W;
   localparam int VW    = bt_pkg::VALUE_W;

   // sequence position and item bookkeeping
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 busy_ff, busy_in;
   logic                 odd_ff, last_ff;
   logic                 accept;
   logic                 ovf_now;

   // wavefront launch registers feeding cell 0
   logic                 launch_act_ff, launch_act_in;
   logic [RW-1:0]        launch_val_ff;
   logic [CNT_W-1:0]     launch_cnt_ff;

   // cell row wiring
   bt_pkg::bt_token_type tok   [MAX_LEN+1];
   logic [CNT_W-1:0]     cnt   [MAX_LEN+1];
   bt_pkg::bt_hit_type   hit   [MAX_LEN];
   logic                 any_hit;
   logic [RW-1:0]        hit_val;

   // pending and output registers
   logic                 pend_valid_ff, pend_valid_in;
   bt_pkg::bt_rsp_type   pend_ff, pend_in;
   logic                 pend_load;
   logic                 out_valid_ff, out_valid_in;
   bt_pkg::bt_rsp_type   out_ff;
   logic                 move;

   // accept only when no item is in flight
   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign ovf_now        = (pos_ff >= POS_W'(MAX_LEN));

   always_comb begin
      launch_act_in = accept && !ovf_now;
      if (req_chan.data.last) begin
         pos_in = '0;
      end else if (ovf_now) begin
         pos_in = POS_W'(MAX_LEN);
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         launch_act_ff <= 1'b0;
      end else begin
         launch_act_ff <= launch_act_in;
         if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   // capture the element and its index for the row
   always_ff @(posedge clock) begin
      if (accept) begin
         launch_val_ff <= {{(RW-VW){req_chan.data.value[VW-1]}}, req_chan.data.value};
         launch_cnt_ff <= pos_ff[CNT_W-1:0];
         odd_ff        <= pos_ff[0];
         last_ff       <= req_chan.data.last;
      end
   end

   assign tok[0].act   = launch_act_ff;
   assign tok[0].value = launch_val_ff;
   assign cnt[0]       = launch_cnt_ff;

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      bt_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (tok[k]),
         .cnt_i (cnt[k]),
         .tok_o (tok[k+1]),
         .cnt_o (cnt[k+1]),
         .hit_o (hit[k])
      );
   end

   // gather the final difference from whichever cell ended the wavefront
   always_comb begin
      any_hit = 1'b0;
      hit_val = '0;
      for (int k = 0; k < MAX_LEN; k++) begin
         any_hit = any_hit | hit[k].hit;
         hit_val = hit_val | (hit[k].value & {RW{hit[k].hit}});
      end
   end

   // load pending from the row, or directly for an overflowing element
   always_comb begin
      pend_load = any_hit || (accept && ovf_now);
      if (any_hit) begin
         pend_in.result   = odd_ff ? (RW'(0) - hit_val) : hit_val;
         pend_in.last_out = last_ff;
         pend_in.overflow = 1'b0;
      end else begin
         pend_in.result   = '0;
         pend_in.last_out = req_chan.data.last;
         pend_in.overflow = 1'b1;
      end
   end

   // advance pending into the output register when that one frees up
   assign move = pend_valid_ff && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      if (pend_load) begin
         pend_valid_in = 1'b1;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end

      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      if (accept) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         busy_ff       <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         busy_ff       <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_load) begin
         pend_ff <= pend_in;
      end
      if (move) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

endmodule

// File: rtl/bt_checker.sv
// ----------------------------------------------------------------------------
// bt_checker
// Port-level checks for the binomial transform stream, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input bt_pkg::bt_rsp_type rsp_data
);

   // hold a stalled result item
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHK_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   // one item in flight: drop ready right after an accept
   `CHK_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   // an overflowing element reports zero
   `CHK_SAME(a_ovf_zero, clock, reset, rsp_valid && rsp_data.overflow, rsp_data.result == '0)
   // no result item right after reset
   `CHK_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind binomial_transform_stream_top bt_checker u_bt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
